// ----- hdl/cfe_pkg.sv -----
package cfe_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 4;

	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_KILL     = 2'd1;
	localparam logic [1:0] OP_KILL_ALL = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	localparam int unsigned FL_RUN  = 0;
	localparam int unsigned FL_HOLD = 1;
	localparam int unsigned FL_LATE = 2;

	localparam int unsigned CHANNELS = 4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  slot;
		logic [31:0] start_rgba;
		logic [31:0] end_rgba;
		logic [15:0] duration;
		logic [15:0] depth;
		logic        one_shot;
		logic        late_group;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  slot_out;
		logic [31:0] colour_rgba;
		logic [15:0] depth_out;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] start_colour;
		logic [31:0] end_colour;
		logic [31:0] current_colour;
		logic [15:0] fade_length;
		logic [15:0] frame_count;
		logic [15:0] slot_depth;
	} slot_entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] start_rgba;
		logic [31:0] end_rgba;
		logic [15:0] len;
		logic [15:0] cnt;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] colour;
	} div_rsp_t;

endpackage

// ----- hdl/cfe_slot_mem.sv -----
module cfe_slot_mem #(
	parameter int unsigned NUM_SLOTS = cfe_pkg::NUM_SLOTS_DEF,
	parameter int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [SW-1:0]        wr_addr,
	input  cfe_pkg::slot_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [SW-1:0]        rd_addr,
	output cfe_pkg::slot_entry_t rd_data
);

	cfe_pkg::slot_entry_t mem [NUM_SLOTS];
	cfe_pkg::slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/cfe_blend_div.sv -----
module cfe_blend_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cfe_pkg::div_req_t req,
	output cfe_pkg::div_rsp_t rsp
);

	localparam int unsigned NW = 24;

	logic          busy_q;
	logic          done_q;
	logic [3:0]    step_q;
	logic [NW-1:0] den_q;
	logic [NW-1:0] num_q [cfe_pkg::CHANNELS];
	logic [7:0]    quo_q [cfe_pkg::CHANNELS];
	logic [15:0]   rem_frames;

	assign rem_frames = req.len - req.cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 4'd8;
			end else if (busy_q) begin
				step_q <= step_q - 4'd1;
				if (step_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [NW:0] prod;
		if (req.start) begin
			den_q <= {1'b0, req.len, 7'b0};
			for (int l = 0; l < cfe_pkg::CHANNELS; l++) begin
				prod = (NW+1)'(req.start_rgba[8*l +: 8]) * (NW+1)'(rem_frames)
				     + (NW+1)'(req.end_rgba[8*l +: 8]) * (NW+1)'(req.cnt);
				num_q[l] <= prod[NW-1:0];
			end
		end else if (busy_q) begin
			den_q <= den_q >> 1;
			for (int l = 0; l < cfe_pkg::CHANNELS; l++) begin
				if (num_q[l] >= den_q) begin
					num_q[l] <= num_q[l] - den_q;
					quo_q[l] <= {quo_q[l][6:0], 1'b1};
				end else begin
					quo_q[l] <= {quo_q[l][6:0], 1'b0};
				end
			end
		end
	end

	assign rsp.done = done_q;

	for (genvar l = 0; l < cfe_pkg::CHANNELS; l++) begin : g_lane
		assign rsp.colour[8*l +: 8] = quo_q[l];
	end

endmodule

// ----- hdl/multi_slot_colour_fade_engine_unit.sv -----
// Multi-slot colour fade engine.
// Input channel (in_valid/in_ready/in_item): start, kill, kill-all or frame tick.
// Output channel (out_valid/out_ready/out_item): one item per drawn slot of a
// tick, in slot order, with last set on the final one. A tick with no visible
// slot produces nothing. Other operations produce nothing.
// Slot data lives in a single-port-write, registered-read memory; slot flags
// are in flops. A tick walks the slots: read, blend, write back, emit.
// Start, kill and kill-all update the slot state without leaving idle. After a
// tick is taken, the walk reads each slot, skips those outside the group,
// writes back visited slots with no blend, and runs the 8-step divider (four
// channels in parallel) for each animating slot, then flushes the held result.
// One result is held back so that last can be set; an output register
// decouples the receiver. When out_ready is low the walk waits at the next
// emitted result, so no item is lost or repeated.
// Reset clears all slot flags (every slot inactive) and the control state.
// No clearing pass is needed: memory contents are only used after a start.
module multi_slot_colour_fade_engine_unit #(
	parameter int unsigned NUM_SLOTS = cfe_pkg::NUM_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cfe_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cfe_pkg::out_item_t out_item
);

	localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_EVAL  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_WB    = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        idx_q;
	logic                 group_q;
	logic [2:0]           flags_q [NUM_SLOTS];
	cfe_pkg::slot_entry_t entry_q;
	logic                 pend_valid_q;
	cfe_pkg::out_item_t   pend_q;
	logic                 out_valid_q;
	cfe_pkg::out_item_t   out_q;

	logic                 in_fire;
	logic [SW+1:0]        slot_ext;
	logic [SW-1:0]        in_idx;
	logic                 in_slot_ok;
	logic [SW-1:0]        cur_idx;
	logic [2:0]           cur_flags;
	logic [CW+1:0]        idx_ext;
	logic                 out_free;
	logic                 push;
	cfe_pkg::out_item_t   push_item;
	logic                 visible;

	logic                 mem_wr_en;
	logic [SW-1:0]        mem_wr_addr;
	cfe_pkg::slot_entry_t mem_wr_data;
	logic                 mem_rd_en;
	cfe_pkg::slot_entry_t mem_rd_data;
	cfe_pkg::div_req_t    div_req;
	cfe_pkg::div_rsp_t    div_rsp;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign slot_ext   = (SW+2)'(in_item.slot);
	assign in_idx     = slot_ext[SW-1:0];
	assign in_slot_ok = slot_ext < (SW+2)'(NUM_SLOTS);
	assign cur_idx    = idx_q[SW-1:0];
	assign cur_flags  = flags_q[cur_idx];
	assign idx_ext    = (CW+2)'(idx_q);
	assign out_free   = !out_valid_q || out_ready;
	assign visible    = cur_flags[cfe_pkg::FL_RUN] || cur_flags[cfe_pkg::FL_HOLD];

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = cur_idx;
		mem_wr_data = entry_q;
		if (in_fire && in_item.operation == cfe_pkg::OP_START && in_slot_ok) begin
			mem_wr_en                  = 1'b1;
			mem_wr_addr                = in_idx;
			mem_wr_data.start_colour   = in_item.start_rgba;
			mem_wr_data.end_colour     = in_item.end_rgba;
			mem_wr_data.current_colour = in_item.start_rgba;
			mem_wr_data.fade_length    = in_item.duration;
			mem_wr_data.frame_count    = '0;
			mem_wr_data.slot_depth     = in_item.depth;
		end else if (state_q == ST_WB) begin
			mem_wr_en = 1'b1;
		end
	end

	assign mem_rd_en = (state_q == ST_READ);

	cfe_slot_mem #(
		.NUM_SLOTS(NUM_SLOTS),
		.SW       (SW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(cur_idx),
		.rd_data(mem_rd_data)
	);

	assign div_req.start = (state_q == ST_EVAL) && cur_flags[cfe_pkg::FL_RUN]
	                    && (mem_rd_data.frame_count < mem_rd_data.fade_length);
	assign div_req.start_rgba = mem_rd_data.start_colour;
	assign div_req.end_rgba   = mem_rd_data.end_colour;
	assign div_req.len        = mem_rd_data.fade_length;
	assign div_req.cnt        = mem_rd_data.frame_count;

	cfe_blend_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// pending result goes out when the next one is produced or at the end
	always_comb begin
		push      = 1'b0;
		push_item = pend_q;
		if (state_q == ST_WB && visible && pend_valid_q && out_free) begin
			push           = 1'b1;
			push_item.last = 1'b0;
		end else if (state_q == ST_FLUSH && pend_valid_q && out_free) begin
			push           = 1'b1;
			push_item.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			group_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				flags_q[i] <= '0;
			end
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_item.operation)
							cfe_pkg::OP_START: begin
								if (in_slot_ok) begin
									flags_q[in_idx] <= {in_item.late_group, !in_item.one_shot, 1'b1};
								end
							end
							cfe_pkg::OP_KILL: begin
								if (in_slot_ok) begin
									flags_q[in_idx] <= '0;
								end
							end
							cfe_pkg::OP_KILL_ALL: begin
								for (int i = 0; i < NUM_SLOTS; i++) begin
									flags_q[i] <= '0;
								end
							end
							cfe_pkg::OP_TICK: begin
								group_q <= in_item.late_group;
								idx_q   <= '0;
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (idx_ext == (CW+2)'(NUM_SLOTS)) begin
						state_q <= ST_FLUSH;
					end else if (cur_flags[cfe_pkg::FL_LATE] == group_q) begin
						state_q <= ST_EVAL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVAL: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end else begin
						if (cur_flags[cfe_pkg::FL_RUN]) begin
							if (cur_flags[cfe_pkg::FL_HOLD]) begin
								flags_q[cur_idx][cfe_pkg::FL_RUN] <= 1'b0;
							end else begin
								flags_q[cur_idx] <= '0;
							end
						end
						state_q <= ST_WB;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (!visible) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end else if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b1;
						idx_q        <= idx_q + 1'b1;
						state_q      <= ST_READ;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_item;
		end
		if (state_q == ST_EVAL) begin
			if (cur_flags[cfe_pkg::FL_RUN] && !div_req.start) begin
				entry_q <= {mem_rd_data.start_colour, mem_rd_data.end_colour,
					mem_rd_data.end_colour, mem_rd_data.fade_length,
					mem_rd_data.frame_count, mem_rd_data.slot_depth};
			end else begin
				entry_q <= mem_rd_data;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			entry_q.current_colour <= div_rsp.colour;
			entry_q.frame_count    <= entry_q.frame_count + 16'd1;
		end
		if (state_q == ST_WB && visible && (!pend_valid_q || out_free)) begin
			pend_q.slot_out    <= idx_ext[1:0];
			pend_q.colour_rgba <= entry_q.current_colour;
			pend_q.depth_out   <= entry_q.slot_depth;
			pend_q.last        <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
